// ----- hdl/bsrq_pkg.sv -----
// ----------------------------------------------------------------------------
// Buffer slot ring queue package
// Request and result types, status and opcode codes shared by the ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bsrq_pkg;

    localparam int LEN_W    = 19;
    localparam int SLOT_W   = 4;
    localparam int HWM_W    = 4;
    localparam int ERRCNT_W = 32;

    localparam logic OP_CLAIM = 1'b0;
    localparam logic OP_TAKE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TOO_BIG = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic             opcode;
        logic [LEN_W-1:0] length;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [SLOT_W-1:0]   slot;
        logic [LEN_W-1:0]    slot_length;
        logic [HWM_W-1:0]    high_water;
        logic [ERRCNT_W-1:0] full_errors;
    } rsp_t;

endpackage

`default_nettype wire

// ----- hdl/bsrq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsrq_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/buffer_slot_ring_queue_top.sv -----
// ----------------------------------------------------------------------------
// Buffer slot ring queue
// Ring of buffer slots with stored lengths, high-water mark and full count.
// ----------------------------------------------------------------------------
// A request (req) is taken at a rising edge where start is high and busy is
// low. Opcode claim reserves the next write slot and stores its length;
// opcode take releases the next read slot and returns its stored length.
// The result (rsp) appears for exactly one cycle, marked by done, in the
// cycle right after the request is taken.
// A new request may be issued in every cycle: the pointers live in flops
// and each request makes at most one access to the length RAM, a write for
// a claim or a read for a take, whose registered data feeds rsp directly.
// busy is never asserted. One slot of the ring is always kept free, so at
// most SLOTS-1 claims are outstanding. high_water and full_errors show the
// values after the request that the result answers.
// Reset clears both pointers, the high-water mark, the full-error counter
// and done. The length RAM needs no clearing pass, since a take reads only
// slots that a claim wrote.
// The receiver cannot stall; results must be taken when done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_slot_ring_queue_top
    import bsrq_pkg::*;
#(
    parameter int SLOTS   = 16,
    parameter int MAX_LEN = 262144
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output logic      done,
    output rsp_t      rsp
);

    localparam int              PTR_W     = $clog2(SLOTS);
    localparam logic [PTR_W:0]  SLOTS_EXT = (PTR_W + 1)'(SLOTS);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);
    localparam logic [31:0]     MAX_LEN_W = 32'(MAX_LEN);

    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]    peak_reg, peak_next;
    logic [ERRCNT_W-1:0] ovf_reg, ovf_next;
    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    logic [PTR_W-1:0]    slot_reg, slot_next;
    logic [LEN_W-1:0]    slen_reg, slen_next;
    logic                take_reg, take_next;

    logic                accept;
    logic [PTR_W:0]      diff;
    logic [PTR_W:0]      occ;
    logic [PTR_W-1:0]    wr_adv;
    logic [PTR_W-1:0]    rd_adv;
    logic                too_big;
    logic                ram_we;
    logic                ram_re;
    logic [LEN_W-1:0]    ram_rdata;
    logic [PTR_W+3:0]    slot_ext;
    logic [PTR_W+3:0]    peak_ext;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign diff    = {1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg};
    assign occ     = (wr_ptr_reg < rd_ptr_reg) ? diff + SLOTS_EXT : diff;
    assign wr_adv  = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_adv  = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
    assign too_big = {13'b0, req.length} > MAX_LEN_W;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        peak_next   = peak_reg;
        ovf_next    = ovf_reg;
        done_next   = accept;
        status_next = ST_OK;
        slot_next   = '0;
        slen_next   = '0;
        take_next   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        if (accept)
        begin
            case (req.opcode)
                OP_CLAIM:
                begin
                    if (too_big)
                    begin
                        status_next = ST_TOO_BIG;
                    end
                    else
                    begin
                        if (occ > {1'b0, peak_reg})
                        begin
                            peak_next = occ[PTR_W-1:0];
                        end
                        if (occ >= {1'b0, LAST_SLOT})
                        begin
                            status_next = ST_FULL;
                            if (ovf_reg != '1)
                            begin
                                ovf_next = ovf_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            wr_ptr_next = wr_adv;
                            ram_we      = 1'b1;
                            slot_next   = wr_adv;
                            slen_next   = req.length;
                        end
                    end
                end
                OP_TAKE:
                begin
                    if (occ == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_ptr_next = rd_adv;
                        ram_re      = 1'b1;
                        slot_next   = rd_adv;
                        take_next   = 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            peak_reg   <= '0;
            ovf_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            peak_reg   <= peak_next;
            ovf_reg    <= ovf_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        slot_reg   <= slot_next;
        slen_reg   <= slen_next;
        take_reg   <= take_next;
    end

    bsrq_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOTS)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_adv),
        .wr_data (req.length),
        .rd_en   (ram_re),
        .rd_addr (rd_adv),
        .rd_data (ram_rdata)
    );

    assign slot_ext = {4'b0, slot_reg};
    assign peak_ext = {4'b0, peak_reg};

    assign done             = done_reg;
    assign rsp.status       = status_reg;
    assign rsp.slot         = slot_ext[SLOT_W-1:0];
    assign rsp.slot_length  = take_reg ? ram_rdata : slen_reg;
    assign rsp.high_water   = peak_ext[HWM_W-1:0];
    assign rsp.full_errors  = ovf_reg;

endmodule

`default_nettype wire

// ----- hdl/bsrq_checker.sv -----
// ----------------------------------------------------------------------------
// Buffer slot ring queue checker
// Port-level assertions on request/result timing and result contents.
// ----------------------------------------------------------------------------
`default_nettype none

module bsrq_checker
    import bsrq_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire req_t req,
    input wire logic done,
    input wire rsp_t rsp
);

    // Every request gets exactly one result in the following cycle.
    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("request without result in the next cycle");

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without a preceding request");

    // A refused request carries no slot and no length.
    a_refused_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> (rsp.slot == '0 && rsp.slot_length == '0))
        else $error("refused request returned a slot or length");

    // A ring-full refusal has always been counted.
    a_full_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_FULL) |-> (rsp.full_errors != '0))
        else $error("full refusal with zero full-error count");

    // A successful claim echoes the requested length.
    a_claim_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.opcode == OP_CLAIM) |=>
        (rsp.status != ST_OK || rsp.slot_length == $past(req.length)))
        else $error("claim result does not echo the length");

endmodule

bind buffer_slot_ring_queue_top bsrq_checker u_bsrq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire

// ----- tb/ring_queue_checker.sv -----
// ----------------------------------------------------------------------------
// Ring queue result checker
// Watches the request and result channels of the buffer slot ring queue. It
// keeps its own model of the pointers, the stored lengths, the high-water
// mark and the full-error count, predicts the response to every request that
// is taken, and compares each result field by field with the oldest
// prediction. It reports mismatch and bookkeeping counts to the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ring_queue_checker
    import bsrq_pkg::*;
#(
    parameter int SLOTS   = 16,
    parameter int MAX_LEN = 262144
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire logic  busy,
    input  wire req_t  req,
    input  wire logic  done,
    input  wire rsp_t  rsp,
    output int unsigned mismatches,
    output int unsigned outstanding,
    output int unsigned checked,
    output int unsigned full_refusals,
    output int unsigned empty_takes,
    output int unsigned oversize_claims
);

    rsp_t              expected_rsp_q[$];
    int                write_slot;
    int                read_slot;
    int                peak_fill;
    logic [31:0]       full_error_total;
    logic [LEN_W-1:0]  stored_length [SLOTS];
    int unsigned       mismatch_count;
    int unsigned       checked_count;
    int unsigned       full_count;
    int unsigned       empty_count;
    int unsigned       oversize_count;
    int unsigned       queue_depth;

    assign mismatches      = mismatch_count;
    assign outstanding     = queue_depth;
    assign checked         = checked_count;
    assign full_refusals   = full_count;
    assign empty_takes     = empty_count;
    assign oversize_claims = oversize_count;

    function automatic int ring_fill();
        return (write_slot >= read_slot) ? write_slot - read_slot
                                         : write_slot + SLOTS - read_slot;
    endfunction

    function automatic int advance(input int p);
        return (p + 1 >= SLOTS) ? 0 : p + 1;
    endfunction

    task automatic predict_response(input req_t r, output rsp_t res);
        int fill;
        res             = '0;
        res.status      = ST_OK;
        fill            = ring_fill();
        if (r.opcode == OP_CLAIM) begin
            if (int'(r.length) > MAX_LEN) begin
                res.status = ST_TOO_BIG;
            end
            else begin
                if (fill > peak_fill) begin
                    peak_fill = fill;
                end
                if (fill >= SLOTS - 1) begin
                    res.status = ST_FULL;
                    if (full_error_total != 32'hFFFF_FFFF) begin
                        full_error_total = full_error_total + 1;
                    end
                end
                else begin
                    write_slot                = advance(write_slot);
                    stored_length[write_slot] = r.length;
                    res.slot                  = SLOT_W'(write_slot);
                    res.slot_length           = r.length;
                end
            end
        end
        else begin
            if (fill == 0) begin
                res.status = ST_EMPTY;
            end
            else begin
                read_slot       = advance(read_slot);
                res.slot        = SLOT_W'(read_slot);
                res.slot_length = stored_length[read_slot];
            end
        end
        res.high_water  = HWM_W'(peak_fill);
        res.full_errors = full_error_total;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        rsp_t predicted;
        rsp_t want;
        if (!rst_n) begin
            expected_rsp_q.delete();
            write_slot       = 0;
            read_slot        = 0;
            peak_fill        = 0;
            full_error_total = '0;
            mismatch_count   = 0;
            checked_count    = 0;
            full_count       = 0;
            empty_count      = 0;
            oversize_count   = 0;
            queue_depth      = 0;
        end
        else begin
            if (start && !busy) begin
                predict_response(req, predicted);
                expected_rsp_q.push_back(predicted);
            end
            if (done) begin
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %p", $time, rsp);
                    mismatch_count++;
                end
                else begin
                    want = expected_rsp_q.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("slot", 32'(want.slot), 32'(rsp.slot));
                    check_field("slot_length", 32'(want.slot_length), 32'(rsp.slot_length));
                    check_field("high_water", 32'(want.high_water), 32'(rsp.high_water));
                    check_field("full_errors", want.full_errors, rsp.full_errors);
                    checked_count++;
                    if (want.status == ST_FULL) begin
                        full_count++;
                    end
                    if (want.status == ST_EMPTY) begin
                        empty_count++;
                    end
                    if (want.status == ST_TOO_BIG) begin
                        oversize_count++;
                    end
                end
            end
            queue_depth = expected_rsp_q.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Buffer slot ring queue testbench
// Drives claim and take requests into the ring queue: a directed opening that
// hits the length limits, an empty take, a full ring and pointer wrap, then
// random phases biased toward filling, draining or mixing the ring, with
// random idle bursts. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import bsrq_pkg::*;

    localparam int SLOTS        = 16;
    localparam int MAX_LEN      = 262144;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_ITEMS  = 100;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        rsp;
    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned checked;
    int unsigned full_refusals;
    int unsigned empty_takes;
    int unsigned oversize_claims;
    int unsigned requests_sent;
    int unsigned cycle_count;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    buffer_slot_ring_queue_top #(
        .SLOTS   (SLOTS),
        .MAX_LEN (MAX_LEN)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    ring_queue_checker #(
        .SLOTS   (SLOTS),
        .MAX_LEN (MAX_LEN)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req             (req),
        .done            (done),
        .rsp             (rsp),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .checked         (checked),
        .full_refusals   (full_refusals),
        .empty_takes     (empty_takes),
        .oversize_claims (oversize_claims)
    );

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, outstanding);
            $display("buffer_slot_ring_queue_top verification failed");
            $finish;
        end
    end

    task automatic issue(input logic op, input logic [LEN_W-1:0] len);
        @(negedge clk);
        start      <= 1'b1;
        req.opcode <= op;
        req.length <= len;
        forever begin
            @(posedge clk);
            if (!busy) begin
                break;
            end
        end
        requests_sent++;
    endtask

    task automatic idle(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    function automatic logic [LEN_W-1:0] legal_length();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return LEN_W'(MAX_LEN);
            default: return LEN_W'($urandom_range(0, MAX_LEN));
        endcase
    endfunction

    initial begin
        int  mode;
        int  claim_pct;
        int  guard;
        logic op;
        logic [LEN_W-1:0] len;

        start         = 1'b0;
        req           = '0;
        rst_n         = 1'b0;
        requests_sent = 0;
        cycle_count   = 0;
        mode          = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        issue(OP_TAKE, LEN_W'($urandom));
        issue(OP_CLAIM, '0);
        issue(OP_CLAIM, LEN_W'(MAX_LEN));
        issue(OP_CLAIM, LEN_W'(MAX_LEN + 1));
        issue(OP_CLAIM, '1);
        issue(OP_TAKE, '1);
        issue(OP_TAKE, '0);
        issue(OP_TAKE, LEN_W'(MAX_LEN));
        for (int i = 0; i < SLOTS - 1; i++) begin
            issue(OP_CLAIM, legal_length());
        end
        issue(OP_CLAIM, '0);
        issue(OP_CLAIM, LEN_W'(MAX_LEN));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                mode = $urandom_range(0, 2);
            end
            claim_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            if (n == RANDOM_ITEMS / 2) begin
                @(negedge clk);
                start <= 1'b0;
                while (outstanding != 0) begin
                    @(negedge clk);
                end
            end
            if (n < RANDOM_ITEMS - QUIET_ITEMS && $urandom_range(0, 3) == 0) begin
                idle($urandom_range(1, 10));
            end
            op = ($urandom_range(1, 100) <= claim_pct) ? OP_CLAIM : OP_TAKE;
            if (op == OP_CLAIM && $urandom_range(0, 9) == 0) begin
                len = LEN_W'($urandom_range(MAX_LEN + 1, (1 << LEN_W) - 1));
            end
            else if (op == OP_CLAIM) begin
                len = legal_length();
            end
            else begin
                len = LEN_W'($urandom);
            end
            issue(op, len);
        end

        @(negedge clk);
        start <= 1'b0;
        guard = 0;
        while (outstanding != 0 && guard < 1000) begin
            @(negedge clk);
            guard++;
        end
        repeat (20) @(negedge clk);

        $display("Sent %0d claim and take requests and checked %0d results,", requests_sent,
                 checked);
        $display("including %0d ring-full refusals, %0d empty takes, %0d oversize claims.",
                 full_refusals, empty_takes, oversize_claims);
        if (outstanding != 0) begin
            $display("%0t: %0d expected results never arrived.", $time, outstanding);
        end
        if (mismatches == 0 && outstanding == 0) begin
            $display("buffer_slot_ring_queue_top verification clean");
        end
        else begin
            $display("buffer_slot_ring_queue_top verification failed");
        end
        $finish;
    end

endmodule

// ----- buffer_slot_ring_queue_top.f -----
hdl/bsrq_pkg.sv
hdl/bsrq_ram.sv
hdl/buffer_slot_ring_queue_top.sv
hdl/bsrq_checker.sv
tb/ring_queue_checker.sv
tb/testbench.sv
